FILE: sv/fftg_pkg.sv
// shared types, constants and tables of the frequency filter transfer generator
package fftg_pkg;

	localparam int MAX_DIM      = 1024;
	localparam int MAX_ORDER    = 8;
	localparam int TAYLOR_TERMS = 12;

	localparam int A_W = 21;    // squared distance
	localparam int B_W = 22;    // squared cutoff
	localparam int G_W = 17;    // gain, q16 up to 1.0

	localparam logic [G_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0]    LN2_Q32 = 32'd2977044472;

	// quotient bits of the three long divisions
	localparam int BW_QBITS = 17;
	localparam int GX_QBITS = 36;
	localparam int GK_QBITS = 5;
	localparam int GAUSS_ZERO_K = 17;

	localparam int GEOM_LAT  = 3;
	localparam int BW_LAT    = 2 * MAX_ORDER + 1 + BW_QBITS;
	localparam int GAUSS_LAT = 1 + GX_QBITS + GK_QBITS + 3 * TAYLOR_TERMS + 1;

	typedef enum logic [2:0] {
		FT_IDEAL_LP = 3'd0,
		FT_IDEAL_HP = 3'd1,
		FT_BW_LP    = 3'd2,
		FT_BW_HP    = 3'd3,
		FT_GAUSS_LP = 3'd4,
		FT_GAUSS_HP = 3'd5
	} filter_type_t;

	typedef enum logic [2:0] {
		REG_FILTER_TYPE   = 3'd0,
		REG_CUTOFF_RADIUS = 3'd1,
		REG_FILTER_ORDER  = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
	} dist_t;

	// floor(2^33 / i) for the taylor term divide
	function automatic logic [33:0] recip33(input int i);
		logic [33:0] m;
		case (i)
			1:       m = 34'd8589934592;
			2:       m = 34'd4294967296;
			3:       m = 34'd2863311530;
			4:       m = 34'd2147483648;
			5:       m = 34'd1717986918;
			6:       m = 34'd1431655765;
			7:       m = 34'd1227133513;
			8:       m = 34'd1073741824;
			9:       m = 34'd954437176;
			10:      m = 34'd858993459;
			11:      m = 34'd780903144;
			12:      m = 34'd715827882;
			default: m = 34'd0;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/fftg_geom.sv
// centering and squared distance stages
module fftg_geom (
	input  logic                clk,
	input  logic                en,
	input  logic [9:0]          coord_u,
	input  logic [9:0]          coord_v,
	input  logic [10:0]         image_width,
	input  logic [10:0]         image_height,
	input  logic [10:0]         cutoff_radius,
	output fftg_pkg::dist_t     dsq
);

	logic [10:0] cw, ch, d0;
	logic [11:0] du_c, dv_c;
	logic [11:0] du_s1, dv_s1;
	logic [10:0] d0_s1;
	logic [23:0] squ, sqv;
	logic [21:0] bsq;
	logic [19:0] du2_s2, dv2_s2;
	logic [21:0] b_s2;
	logic [20:0] a_s3;
	logic [21:0] b_s3;

	always_comb begin
		cw = (image_width > 11'(fftg_pkg::MAX_DIM)) ? 11'(fftg_pkg::MAX_DIM) : image_width;
		ch = (image_height > 11'(fftg_pkg::MAX_DIM)) ? 11'(fftg_pkg::MAX_DIM) : image_height;
		du_c = {2'b00, coord_u} - {2'b00, cw[10:1]};
		dv_c = {2'b00, coord_v} - {2'b00, ch[10:1]};
		d0 = (cutoff_radius == 11'd0) ? 11'd1 : cutoff_radius;
	end

	assign squ = {{12{du_s1[11]}}, du_s1} * {{12{du_s1[11]}}, du_s1};
	assign sqv = {{12{dv_s1[11]}}, dv_s1} * {{12{dv_s1[11]}}, dv_s1};
	assign bsq = {11'd0, d0_s1} * {11'd0, d0_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			du_s1  <= du_c;
			dv_s1  <= dv_c;
			d0_s1  <= d0;
			du2_s2 <= squ[19:0];
			dv2_s2 <= sqv[19:0];
			b_s2   <= bsq;
			a_s3   <= {1'b0, du2_s2} + {1'b0, dv2_s2};
			b_s3   <= b_s2;
		end
	end

	assign dsq.a = a_s3;
	assign dsq.b = b_s3;

endmodule

FILE: sv/fftg_bw.sv
// butterworth power chain and ratio divider
module fftg_bw (
	input  logic            clk,
	input  logic            en,
	input  fftg_pkg::dist_t dsq,
	input  logic [3:0]      filter_order,
	input  logic            high,
	output logic [16:0]     gain
);

	localparam int STEPS = fftg_pkg::MAX_ORDER;
	localparam int QB    = fftg_pkg::BW_QBITS;

	function automatic logic [5:0] norm_shift(input logic [53:0] m);
		logic [5:0] s;
		s = 6'd0;
		for (int j = 0; j < 22; j++) begin
			if (m[32+j]) s = 6'(j + 1);
		end
		return s;
	endfunction

	logic [4:0]  n;
	logic [31:0] pa_src [STEPS];
	logic [31:0] pb_src [STEPS];
	logic [20:0] a_src  [STEPS];
	logic [21:0] b_src  [STEPS];
	logic [53:0] pam_s  [STEPS];
	logic [53:0] pbm_s  [STEPS];
	logic [20:0] am_s   [STEPS];
	logic [21:0] bm_s   [STEPS];
	logic [31:0] pa_s   [STEPS];
	logic [31:0] pb_s   [STEPS];
	logic [20:0] an_s   [STEPS];
	logic [21:0] bn_s   [STEPS];
	logic [5:0]  sh     [STEPS];

	always_comb begin
		if (filter_order == 4'd0)
			n = 5'd1;
		else if ({1'b0, filter_order} > 5'(fftg_pkg::MAX_ORDER))
			n = 5'(fftg_pkg::MAX_ORDER);
		else
			n = {1'b0, filter_order};
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_pow
		if (g == 0) begin : g_first
			assign pa_src[g] = 32'd1;
			assign pb_src[g] = 32'd1;
			assign a_src[g]  = dsq.a;
			assign b_src[g]  = dsq.b;
		end else begin : g_next
			assign pa_src[g] = pa_s[g-1];
			assign pb_src[g] = pb_s[g-1];
			assign a_src[g]  = an_s[g-1];
			assign b_src[g]  = bn_s[g-1];
		end

		assign sh[g] = norm_shift(pam_s[g] | pbm_s[g]);

		always_ff @(posedge clk) begin
			if (en) begin
				am_s[g] <= a_src[g];
				bm_s[g] <= b_src[g];
				if (5'(g) < n) begin
					pam_s[g] <= {22'd0, pa_src[g]} * {33'd0, a_src[g]};
					pbm_s[g] <= {22'd0, pb_src[g]} * {32'd0, b_src[g]};
				end else begin
					pam_s[g] <= {22'd0, pa_src[g]};
					pbm_s[g] <= {22'd0, pb_src[g]};
				end
				pa_s[g] <= 32'(pam_s[g] >> sh[g]);
				pb_s[g] <= 32'(pbm_s[g] >> sh[g]);
				an_s[g] <= am_s[g];
				bn_s[g] <= bm_s[g];
			end
		end
	end

	// ratio setup
	logic [32:0] sum_c;
	logic [31:0] num_c;
	logic [48:0] dvd_c;
	logic [32:0] s_su;
	logic [31:0] rem_su;
	logic [16:0] lo_su;

	always_comb begin
		sum_c = {1'b0, pa_s[STEPS-1]} + {1'b0, pb_s[STEPS-1]};
		num_c = high ? pa_s[STEPS-1] : pb_s[STEPS-1];
		dvd_c = {1'b0, num_c, 16'd0} + {17'd0, sum_c[32:1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_su   <= sum_c;
			rem_su <= dvd_c[48:17];
			lo_su  <= dvd_c[16:0];
		end
	end

	// restoring divide, one quotient bit per stage
	logic [32:0] rem_src [QB];
	logic [16:0] q_src   [QB];
	logic [16:0] lo_src  [QB];
	logic [32:0] s_src   [QB];
	logic [32:0] rem_d_s [QB];
	logic [16:0] q_d_s   [QB];
	logic [16:0] lo_d_s  [QB];
	logic [32:0] s_d_s   [QB];

	for (genvar g = 0; g < QB; g++) begin : g_div
		logic [33:0] t;
		logic        ge;
		if (g == 0) begin : g_first
			assign rem_src[g] = {1'b0, rem_su};
			assign q_src[g]   = 17'd0;
			assign lo_src[g]  = lo_su;
			assign s_src[g]   = s_su;
		end else begin : g_next
			assign rem_src[g] = rem_d_s[g-1];
			assign q_src[g]   = q_d_s[g-1];
			assign lo_src[g]  = lo_d_s[g-1];
			assign s_src[g]   = s_d_s[g-1];
		end

		assign t  = {rem_src[g], lo_src[g][QB-1-g]};
		assign ge = (t >= {1'b0, s_src[g]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d_s[g] <= ge ? 33'(t - {1'b0, s_src[g]}) : t[32:0];
				q_d_s[g]   <= {q_src[g][15:0], ge};
				lo_d_s[g]  <= lo_src[g];
				s_d_s[g]   <= s_src[g];
			end
		end
	end

	assign gain = q_d_s[QB-1];

endmodule

FILE: sv/fftg_gauss.sv
// gaussian low pass gain: scaled divide, range reduction, taylor exp
module fftg_gauss (
	input  logic            clk,
	input  logic            en,
	input  fftg_pkg::dist_t dsq,
	output logic [16:0]     gain
);

	localparam int XB = fftg_pkg::GX_QBITS;
	localparam int KB = fftg_pkg::GK_QBITS;
	localparam int NT = fftg_pkg::TAYLOR_TERMS;

	// front: a*2^31/b split into top remainder and five live dividend bits
	logic [21:0] rem_f_s1;
	logic [4:0]  lo_f_s1;
	logic        ovf_f_s1;
	logic [21:0] b_f_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_f_s1 <= {6'd0, dsq.a[20:5]};
			lo_f_s1  <= dsq.a[4:0];
			ovf_f_s1 <= ({6'd0, dsq.a[20:5]} >= dsq.b);
			b_f_s1   <= dsq.b;
		end
	end

	logic [21:0] xr_src [XB];
	logic [35:0] x_src  [XB];
	logic [4:0]  lo_src [XB];
	logic        ov_src [XB];
	logic [21:0] b_src  [XB];
	logic [21:0] xr_s   [XB];
	logic [35:0] x_s    [XB];
	logic [4:0]  lo_s   [XB];
	logic        ov_s   [XB];
	logic [21:0] b_s    [XB];

	for (genvar g = 0; g < XB; g++) begin : g_xdiv
		logic        nb;
		logic [22:0] t;
		logic        ge;
		if (g == 0) begin : g_first
			assign xr_src[g] = rem_f_s1;
			assign x_src[g]  = 36'd0;
			assign lo_src[g] = lo_f_s1;
			assign ov_src[g] = ovf_f_s1;
			assign b_src[g]  = b_f_s1;
		end else begin : g_next
			assign xr_src[g] = xr_s[g-1];
			assign x_src[g]  = x_s[g-1];
			assign lo_src[g] = lo_s[g-1];
			assign ov_src[g] = ov_s[g-1];
			assign b_src[g]  = b_s[g-1];
		end
		if (g < 5) begin : g_live
			assign nb = lo_src[g][4-g];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign t  = {xr_src[g], nb};
		assign ge = (t >= {1'b0, b_src[g]});

		always_ff @(posedge clk) begin
			if (en) begin
				xr_s[g] <= ge ? 22'(t - {1'b0, b_src[g]}) : t[21:0];
				x_s[g]  <= {x_src[g][34:0], ge};
				lo_s[g] <= lo_src[g];
				ov_s[g] <= ov_src[g];
				b_s[g]  <= b_src[g];
			end
		end
	end

	// range reduction by ln 2
	logic [35:0] kr_src [KB];
	logic [4:0]  k_src  [KB];
	logic        kov_src[KB];
	logic [35:0] kr_s   [KB];
	logic [4:0]  k_s    [KB];
	logic        kov_s  [KB];

	for (genvar g = 0; g < KB; g++) begin : g_kdiv
		logic [36:0] lim;
		logic        ge;
		if (g == 0) begin : g_first
			assign kr_src[g]  = x_s[XB-1];
			assign k_src[g]   = 5'd0;
			assign kov_src[g] = ov_s[XB-1];
		end else begin : g_next
			assign kr_src[g]  = kr_s[g-1];
			assign k_src[g]   = k_s[g-1];
			assign kov_src[g] = kov_s[g-1];
		end

		assign lim = {5'd0, fftg_pkg::LN2_Q32} << (KB - 1 - g);
		assign ge  = ({1'b0, kr_src[g]} >= lim);

		always_ff @(posedge clk) begin
			if (en) begin
				kr_s[g]  <= ge ? 36'({1'b0, kr_src[g]} - lim) : kr_src[g];
				k_s[g]   <= {k_src[g][3:0], ge};
				kov_s[g] <= kov_src[g];
			end
		end
	end

	logic zero_c;
	assign zero_c = kov_s[KB-1] || (k_s[KB-1] >= 5'(fftg_pkg::GAUSS_ZERO_K));

	// taylor series, three stages per term: product, reciprocal, correction
	logic [32:0] tm_src [NT];
	logic [33:0] e_src  [NT];
	logic [31:0] r_src  [NT];
	logic [4:0]  k_tsrc [NT];
	logic        z_src  [NT];

	logic [32:0] y1_s [NT];
	logic [33:0] e1_s [NT];
	logic [31:0] r1_s [NT];
	logic [4:0]  k1_s [NT];
	logic        z1_s [NT];

	logic [32:0] q2_s [NT];
	logic [32:0] y2_s [NT];
	logic [33:0] e2_s [NT];
	logic [31:0] r2_s [NT];
	logic [4:0]  k2_s [NT];
	logic        z2_s [NT];

	logic [32:0] tm3_s [NT];
	logic [33:0] e3_s  [NT];
	logic [31:0] r3_s  [NT];
	logic [4:0]  k3_s  [NT];
	logic        z3_s  [NT];

	for (genvar g = 0; g < NT; g++) begin : g_term
		localparam logic [33:0] RCP = fftg_pkg::recip33(g + 1);
		logic [64:0] p1;
		logic [66:0] p2;
		logic [36:0] qi;
		logic [36:0] rm;
		logic [32:0] q;

		if (g == 0) begin : g_first
			assign tm_src[g] = 33'h1_0000_0000;
			assign e_src[g]  = 34'h0_1_0000_0000;
			assign r_src[g]  = kr_s[KB-1][31:0];
			assign k_tsrc[g] = k_s[KB-1];
			assign z_src[g]  = zero_c;
		end else begin : g_next
			assign tm_src[g] = tm3_s[g-1];
			assign e_src[g]  = e3_s[g-1];
			assign r_src[g]  = r3_s[g-1];
			assign k_tsrc[g] = k3_s[g-1];
			assign z_src[g]  = z3_s[g-1];
		end

		assign p1 = {32'd0, tm_src[g]} * {33'd0, r_src[g]};
		assign p2 = {34'd0, y1_s[g]} * {33'd0, RCP};
		assign qi = {4'd0, q2_s[g]} * 37'(g + 1);
		assign rm = {4'd0, y2_s[g]} - qi;
		assign q  = (rm >= 37'(g + 1)) ? 33'(q2_s[g] + 33'd1) : q2_s[g];

		always_ff @(posedge clk) begin
			if (en) begin
				y1_s[g]  <= p1[64:32];
				e1_s[g]  <= e_src[g];
				r1_s[g]  <= r_src[g];
				k1_s[g]  <= k_tsrc[g];
				z1_s[g]  <= z_src[g];

				q2_s[g]  <= p2[65:33];
				y2_s[g]  <= y1_s[g];
				e2_s[g]  <= e1_s[g];
				r2_s[g]  <= r1_s[g];
				k2_s[g]  <= k1_s[g];
				z2_s[g]  <= z1_s[g];

				tm3_s[g] <= q;
				e3_s[g]  <= (g % 2 == 0) ? 34'(e2_s[g] - {1'b0, q}) : 34'(e2_s[g] + {1'b0, q});
				r3_s[g]  <= r2_s[g];
				k3_s[g]  <= k2_s[g];
				z3_s[g]  <= z2_s[g];
			end
		end
	end

	// scale by 2^-k with rounding
	logic [34:0] rnd_c;
	logic [34:0] sc_c;
	logic [16:0] gain_s;

	always_comb begin
		rnd_c = {1'b0, e3_s[NT-1]} + (35'd1 << (6'd15 + {1'b0, k3_s[NT-1]}));
		sc_c  = rnd_c >> (6'd16 + {1'b0, k3_s[NT-1]});
	end

	always_ff @(posedge clk) begin
		if (en)
			gain_s <= z3_s[NT-1] ? 17'd0 : sc_c[16:0];
	end

	assign gain = gain_s;

endmodule

FILE: sv/frequency_filter_transfer_gen.sv
// top level: config registers, pipeline control, filter type select
//
// channel  | handshake               | word
// ---------+-------------------------+-------------------------
// input    | in_valid / in_stall     | coord_u, coord_v
// output   | out_valid / out_stall   | transfer_value
// config   | cfg_we                  | cfg_index, cfg_data
//
// one word enters per cycle while in_stall is low; pipeline depth is set by the gaussian path
// (36-bit scaled divide, ln 2 reduction, 12-term taylor series at 3 stages a term)
// arst_n clears the valid bits and the config registers to their defaults
// a stalled valid output freezes every stage at once; in_stall follows it
module frequency_filter_transfer_gen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  coord_u,
	input  logic [9:0]  coord_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] transfer_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int BW_PAD     = fftg_pkg::GAUSS_LAT - fftg_pkg::BW_LAT;
	localparam int IDEAL_PAD  = fftg_pkg::GAUSS_LAT;
	localparam int PIPE_DEPTH = fftg_pkg::GEOM_LAT + fftg_pkg::GAUSS_LAT + 1;

	// config registers
	logic [2:0]  filter_type_q;
	logic [10:0] cutoff_radius_q;
	logic [3:0]  filter_order_q;
	logic [10:0] image_width_q;
	logic [10:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_type_q   <= fftg_pkg::FT_IDEAL_LP;
			cutoff_radius_q <= 11'd16;
			filter_order_q  <= 4'd1;
			image_width_q   <= 11'd128;
			image_height_q  <= 11'd128;
		end else if (cfg_we) begin
			case (fftg_pkg::cfg_index_t'(cfg_index))
				fftg_pkg::REG_FILTER_TYPE:   filter_type_q   <= cfg_data[2:0];
				fftg_pkg::REG_CUTOFF_RADIUS: cutoff_radius_q <= cfg_data;
				fftg_pkg::REG_FILTER_ORDER:  filter_order_q  <= cfg_data[3:0];
				fftg_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				fftg_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a finished word is held at the output
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_s;

	assign en       = !(vld_s[PIPE_DEPTH-1] && out_stall);
	assign in_stall = vld_s[PIPE_DEPTH-1] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_DEPTH-2:0], in_valid};
	end

	// squared distance and squared cutoff
	fftg_pkg::dist_t dsq;

	fftg_geom u_geom (
		.clk           (clk),
		.en            (en),
		.coord_u       (coord_u),
		.coord_v       (coord_v),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.cutoff_radius (cutoff_radius_q),
		.dsq           (dsq)
	);

	// butterworth branch, high pass picks the distance power as numerator
	logic [16:0] bw_gain;

	fftg_bw u_bw (
		.clk          (clk),
		.en           (en),
		.dsq          (dsq),
		.filter_order (filter_order_q),
		.high         (filter_type_q == fftg_pkg::FT_BW_HP),
		.gain         (bw_gain)
	);

	// gaussian low pass branch
	logic [16:0] ga_gain;

	fftg_gauss u_gauss (
		.clk  (clk),
		.en   (en),
		.dsq  (dsq),
		.gain (ga_gain)
	);

	// line up the short branches with the gaussian one
	logic [16:0] bw_dly_s    [BW_PAD];
	logic        inside_dly_s[IDEAL_PAD];

	always_ff @(posedge clk) begin
		if (en) begin
			bw_dly_s[0]     <= bw_gain;
			inside_dly_s[0] <= (dsq.a <= 21'(dsq.b)) && (dsq.b[21] == 1'b0) ||
				dsq.b[21];
			for (int i = 1; i < BW_PAD; i++)
				bw_dly_s[i] <= bw_dly_s[i-1];
			for (int i = 1; i < IDEAL_PAD; i++)
				inside_dly_s[i] <= inside_dly_s[i-1];
		end
	end

	// final select by filter type, unknown codes give zero
	logic        in_ring;
	logic [16:0] sel_c;
	logic [16:0] transfer_s;

	assign in_ring = inside_dly_s[IDEAL_PAD-1];

	always_comb begin
		case (fftg_pkg::filter_type_t'(filter_type_q))
			fftg_pkg::FT_IDEAL_LP: sel_c = in_ring ? fftg_pkg::ONE_Q16 : 17'd0;
			fftg_pkg::FT_IDEAL_HP: sel_c = in_ring ? 17'd0 : fftg_pkg::ONE_Q16;
			fftg_pkg::FT_BW_LP:    sel_c = bw_dly_s[BW_PAD-1];
			fftg_pkg::FT_BW_HP:    sel_c = bw_dly_s[BW_PAD-1];
			fftg_pkg::FT_GAUSS_LP: sel_c = ga_gain;
			fftg_pkg::FT_GAUSS_HP: sel_c = fftg_pkg::ONE_Q16 - ga_gain;
			default:               sel_c = 17'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			transfer_s <= sel_c;
	end

	assign out_valid      = vld_s[PIPE_DEPTH-1];
	assign transfer_value = transfer_s;

endmodule

FILE: sv/fftg_checker.sv
// port checker for the frequency filter transfer generator, with its bind
module fftg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [16:0] transfer_value
);

	// a held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(transfer_value))
		else $error("output word changed while stalled");

	// gain never above 1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> transfer_value <= 17'd65536)
		else $error("gain above 1.0");

	// input only backs up behind a stalled output word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held output");

	// nothing comes out right after reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

endmodule

bind frequency_filter_transfer_gen fftg_checker u_fftg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.transfer_value (transfer_value)
);

FILE: test/fftg_checker.sv
// checker for the frequency filter transfer generator: predicts gains and compares them
module fftg_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [9:0]  coord_u,
	input  logic [9:0]  coord_v,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [16:0] transfer_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [2:0]  ftype;
	logic [10:0] cutoff;
	logic [3:0]  order;
	logic [10:0] img_w;
	logic [10:0] img_h;

	logic [16:0] gain_queue[$];

	function automatic logic [16:0] butterworth_gain(bit [63:0] a, bit [63:0] b, int n,
		bit high);
		bit [63:0] pa, pb, s, num;
		pa = 1;
		pb = 1;
		for (int i = 0; i < n; i++) begin
			pa = pa * a;
			pb = pb * b;
			while (pa >= 64'h1_0000_0000 || pb >= 64'h1_0000_0000) begin
				pa = pa >> 1;
				pb = pb >> 1;
			end
		end
		s = pa + pb;
		num = high ? pa : pb;
		return 17'((num * 64'd65536 + s / 2) / s);
	endfunction

	function automatic logic [16:0] gauss_low_gain(bit [63:0] a, bit [63:0] b);
		bit [63:0] x, k, r, term, e, ln2;
		ln2 = 64'(fftg_pkg::LN2_Q32);
		x = (a << 31) / b;
		k = x / ln2;
		r = x - k * ln2;
		if (k >= fftg_pkg::GAUSS_ZERO_K)
			return '0;
		term = 64'h1_0000_0000;
		e = 64'h1_0000_0000;
		for (int i = 1; i <= fftg_pkg::TAYLOR_TERMS; i++) begin
			term = ((term * r) >> 32) / i;
			if (i % 2)
				e = e - term;
			else
				e = e + term;
		end
		return 17'((e + (64'd1 << (15 + k))) >> (16 + k));
	endfunction

	function automatic logic [16:0] predict_gain(logic [9:0] u, logic [9:0] v);
		int cw, ch, du, dv, n;
		bit [63:0] a, b, d0;
		logic [16:0] g;
		cw = (img_w > fftg_pkg::MAX_DIM) ? fftg_pkg::MAX_DIM : int'(img_w);
		ch = (img_h > fftg_pkg::MAX_DIM) ? fftg_pkg::MAX_DIM : int'(img_h);
		du = int'(u) - cw / 2;
		dv = int'(v) - ch / 2;
		a = 64'(du * du + dv * dv);
		d0 = (cutoff == 0) ? 64'd1 : 64'(cutoff);
		b = d0 * d0;
		n = (order == 0) ? 1 :
			((order > fftg_pkg::MAX_ORDER) ? fftg_pkg::MAX_ORDER : int'(order));
		case (ftype)
			fftg_pkg::FT_IDEAL_LP: g = (a <= b) ? fftg_pkg::ONE_Q16 : '0;
			fftg_pkg::FT_IDEAL_HP: g = (a <= b) ? '0 : fftg_pkg::ONE_Q16;
			fftg_pkg::FT_BW_LP:    g = butterworth_gain(a, b, n, 1'b0);
			fftg_pkg::FT_BW_HP:    g = butterworth_gain(a, b, n, 1'b1);
			fftg_pkg::FT_GAUSS_LP: g = gauss_low_gain(a, b);
			fftg_pkg::FT_GAUSS_HP: g = fftg_pkg::ONE_Q16 - gauss_low_gain(a, b);
			default:               g = '0;
		endcase
		return g;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftype <= fftg_pkg::FT_IDEAL_LP;
			cutoff <= 11'd16;
			order <= 4'd1;
			img_w <= 11'd128;
			img_h <= 11'd128;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fftg_pkg::REG_FILTER_TYPE:   ftype <= cfg_data[2:0];
					fftg_pkg::REG_CUTOFF_RADIUS: cutoff <= cfg_data;
					fftg_pkg::REG_FILTER_ORDER:  order <= cfg_data[3:0];
					fftg_pkg::REG_IMAGE_WIDTH:   img_w <= cfg_data;
					fftg_pkg::REG_IMAGE_HEIGHT:  img_h <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				gain_queue.push_back(predict_gain(coord_u, coord_v));
			if (out_valid && !out_stall) begin
				if (gain_queue.size() == 0) begin
					$error("transfer_value: unexpected word %0d", transfer_value);
					fail_count <= fail_count + 1;
				end else begin
					logic [16:0] want;
					want = gain_queue.pop_front();
					if (want !== transfer_value) begin
						$error("transfer_value: expected %0d, actual %0d", want, transfer_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= gain_queue.size();
		end
	end

endmodule

FILE: test/frequency_filter_transfer_gen_test.sv
// testbench top: drives coordinates and register settings, gives the verdict
module frequency_filter_transfer_gen_test;
	timeunit 1ns;
	timeprecision 1ps;

	// register indexes past the last one, writes there must be ignored
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;    // longer than the pipeline is deep
	localparam int PHASES = 16;
	localparam int WORDS_PER_PHASE = 83;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  coord_u = '0;
	logic [9:0]  coord_v = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [16:0] transfer_value;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	bit          calm = 1'b0;       // no gaps and no stalls while set
	int          cur_w = 128;       // image size in force, to aim coordinates
	int          cur_h = 128;
	int          cur_r = 16;

	frequency_filter_transfer_gen dut (.*);

	fftg_scoreboard checker_i (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stall before each word, none while calm
	initial begin
		int hold;
		bit st;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			// word taken at the edge after a valid seen with stall low
			do begin
				@(negedge clk);
				st = out_valid;
				@(posedge clk);
			end while (!st);
		end
	end

	// one register write per cycle, we stays high across back to back writes
	task automatic write_reg(logic [2:0] idx, logic [10:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// send one coordinate word with a random gap ahead of it
	task automatic send_coord(logic [9:0] u, logic [9:0] v);
		int gap;
		bit st;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_u <= u;
		coord_v <= v;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
	endtask

	// wait for every expected gain, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [9:0] aim(int c, int limit);
		if (c < 0)
			return '0;
		if (c > limit)
			return 10'(limit);
		return 10'(c);
	endfunction

	// mostly coordinates inside the image, near the cutoff ring or anywhere else
	task automatic send_random_coord();
		int pick, w, h, du, dv;
		w = (cur_w > fftg_pkg::MAX_DIM) ? fftg_pkg::MAX_DIM : ((cur_w < 1) ? 1 : cur_w);
		h = (cur_h > fftg_pkg::MAX_DIM) ? fftg_pkg::MAX_DIM : ((cur_h < 1) ? 1 : cur_h);
		pick = $urandom_range(0, 9);
		if (pick < 5)
			send_coord(10'($urandom_range(0, w - 1)), 10'($urandom_range(0, h - 1)));
		else if (pick < 8) begin
			du = $urandom_range(0, cur_r + 2);
			dv = $urandom_range(0, 2);
			if ($urandom_range(0, 1))
				send_coord(aim(w / 2 + du, 1023), aim(h / 2 - dv, 1023));
			else
				send_coord(aim(w / 2 - dv, 1023), aim(h / 2 - du, 1023));
		end else
			send_coord(10'($urandom), 10'($urandom));
	endtask

	initial begin
		logic [2:0]  ft;
		logic [10:0] rad, wid, hgt;
		logic [3:0]  ord;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words on reset settings: corners, center, cutoff ring
		send_coord(10'd0, 10'd0);
		send_coord(10'd1023, 10'd1023);
		send_coord(10'd0, 10'd1023);
		send_coord(10'd1023, 10'd0);
		send_coord(10'd64, 10'd64);
		send_coord(10'd80, 10'd64);
		send_coord(10'd81, 10'd64);
		send_coord(10'd64, 10'd48);
		send_coord(10'd64, 10'd47);
		send_coord(10'd127, 10'd127);
		send_coord(10'h2AA, 10'h155);
		send_coord(10'h155, 10'h2AA);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// every type code, the unused ones too, then random ones
			ft = (p < 8) ? 3'(p) : 3'($urandom_range(0, 5));
			case (p % 6)
				0: begin rad = 11'd0;    ord = 4'd0;  wid = 11'd1;    hgt = 11'd2047; end
				1: begin rad = 11'd1;    ord = 4'd8;  wid = 11'd1024; hgt = 11'd1;    end
				2: begin rad = 11'd1024; ord = 4'd15; wid = 11'd2047; hgt = 11'd1024; end
				3: begin rad = 11'd2047; ord = 4'd1;  wid = 11'd128;  hgt = 11'd128;  end
				default: begin
					rad = 11'($urandom_range(1, 200));
					ord = 4'($urandom);
					wid = 11'($urandom_range(1, 2047));
					hgt = 11'($urandom_range(1, 2047));
				end
			endcase
			write_reg(fftg_pkg::REG_FILTER_TYPE, {8'($urandom), ft});
			write_reg(fftg_pkg::REG_CUTOFF_RADIUS, rad);
			write_reg(fftg_pkg::REG_FILTER_ORDER, {7'($urandom), ord});
			write_reg(fftg_pkg::REG_IMAGE_WIDTH, wid);
			write_reg(fftg_pkg::REG_IMAGE_HEIGHT, hgt);
			// spare indexes carry junk that must not land anywhere
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 11'($urandom));
			end_writes();
			cur_w = wid;
			cur_h = hgt;
			cur_r = (rad == 0) ? 1 : rad;
			calm = (p % 5 == 4);
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				send_random_coord();
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
